// ===== rtl/core/fslt_pkg.sv =====
// Shared types and constants for the flash sector locator and tracker.
// Depends on nothing; every core module imports it.
package fslt_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned GROUP_W    = 40;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned USED_W     = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned NUM_GROUP_REGS = 4;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TOTAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_USED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ZERO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ONE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_TWO   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_THREE = 3'd6;

	// Register reset values
	localparam logic [ADDR_W-1:0]  RST_FLASH_BASE  = 32'h0800_0000;
	localparam logic [ADDR_W-1:0]  RST_FLASH_TOTAL = 32'h0008_0000;
	localparam logic [USED_W-1:0]  RST_GROUPS_USED = 3'd3;
	localparam logic [GROUP_W-1:0] RST_GROUP_ZERO  = 40'h04_0000_4000;
	localparam logic [GROUP_W-1:0] RST_GROUP_ONE   = 40'h01_0001_0000;
	localparam logic [GROUP_W-1:0] RST_GROUP_TWO   = 40'h03_0002_0000;
	localparam logic [GROUP_W-1:0] RST_GROUP_THREE = 40'h00_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_FIN
	} fslt_state_t;

	typedef enum logic [1:0] {
		FIN_HIT,
		FIN_MISS,
		FIN_INIT
	} fslt_fin_t;

	// Controller to datapath
	typedef struct packed {
		logic      load;
		logic      setup;
		logic      mul;
		logic      advance;
		logic      div_start;
		logic      fin;
		fslt_fin_t kind;
	} fslt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic mode_init;
		logic in_range;
		logic grp_left;
		logic grp_hit;
		logic div_done;
		logic out_busy;
	} fslt_sts_t;

endpackage

// ===== rtl/core/fslt_div.sv =====
// Iterative remainder unit: one restoring step per cycle over 32 bits.
// Depends on fslt_pkg for the address width.
module fslt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fslt_pkg::ADDR_W-1:0] dividend,
	input  logic [fslt_pkg::ADDR_W-1:0] divisor,
	output logic                       done,
	output logic [fslt_pkg::ADDR_W-1:0] remainder
);
	import fslt_pkg::*;

	localparam int unsigned CNT_W = $clog2(ADDR_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] dvd_q;
	logic [ADDR_W-1:0] dvs_q;
	logic [ADDR_W-1:0] rem_q;
	logic [ADDR_W:0]   trial;

	// Shift in the next dividend bit
	assign trial = {rem_q, dvd_q[ADDR_W-1]};

	// Count the remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(ADDR_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Advance the partial remainder, subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[ADDR_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= ADDR_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[ADDR_W-1:0];
			end
		end
	end

	assign done      = (cnt_q == '0);
	assign remainder = rem_q;

endmodule

// ===== rtl/core/fslt_ctrl.sv =====
// Controller state machine: sequences range check, group walk, remainder and finish.
// Depends on fslt_pkg for state, command and status types.
module fslt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fslt_pkg::fslt_sts_t  sts,
	output fslt_pkg::fslt_cmd_t  cmd
);
	import fslt_pkg::*;

	fslt_state_t state_q, state_d;
	fslt_fin_t   kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= FIN_MISS;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// Next state and finish kind
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RANGE;
			end
			ST_RANGE: begin
				if (sts.mode_init) begin
					kind_d  = FIN_INIT;
					state_d = ST_FIN;
				end else if (!sts.in_range) begin
					kind_d  = FIN_MISS;
					state_d = ST_FIN;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (!sts.grp_left) begin
					kind_d  = FIN_MISS;
					state_d = ST_FIN;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.grp_hit) state_d = ST_DIV;
				else             state_d = ST_MUL;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					kind_d  = FIN_HIT;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd      = '0;
		cmd.kind = kind_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RANGE: cmd.setup = 1'b1;
			ST_MUL:   cmd.mul = sts.grp_left;
			ST_CMP: begin
				cmd.div_start = sts.grp_hit;
				cmd.advance   = !sts.grp_hit;
			end
			ST_DIV: ;
			ST_FIN:   cmd.fin = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/fslt_dp.sv =====
// Datapath: configuration registers, group walk, tracking state and output register.
// Depends on fslt_pkg and instantiates fslt_div.
module fslt_dp #(
	parameter int unsigned MAX_GROUPS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fslt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fslt_pkg::GROUP_W-1:0]    cfg_data,
	input  logic                            in_mode,
	input  logic [fslt_pkg::ADDR_W-1:0]     in_address,
	input  fslt_pkg::fslt_cmd_t             cmd,
	output fslt_pkg::fslt_sts_t             sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            out_found,
	output logic                            out_erase,
	output logic [fslt_pkg::ADDR_W-1:0]     out_base,
	output logic [fslt_pkg::ADDR_W-1:0]     out_bytes
);
	import fslt_pkg::*;

	// Group counter must reach MAX_GROUPS and index the four group registers
	localparam int unsigned CW = (MAX_GROUPS > 7) ? 4 : 3;

	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  total_q;
	logic [USED_W-1:0]  used_q;
	logic [GROUP_W-1:0] grp_q [NUM_GROUP_REGS];

	logic               mode_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  cur_q;
	logic [CW-1:0]      idx_q;
	logic [GROUP_W-1:0] span_q;
	logic [ADDR_W-1:0]  gsz_q;

	logic               tv_q;
	logic [ADDR_W-1:0]  ts_q;
	logic [ADDR_W-1:0]  tsz_q;

	logic               out_valid_q;
	logic               out_found_q;
	logic               out_erase_q;
	logic [ADDR_W-1:0]  out_base_q;
	logic [ADDR_W-1:0]  out_bytes_q;

	logic [CW-1:0]      used_ext;
	logic [CW-1:0]      n_eff;
	logic [GROUP_W-1:0] grp_sel;
	logic [ADDR_W-1:0]  offset;
	logic [ADDR_W:0]    end_addr;
	logic [ADDR_W-1:0]  cur_next;
	logic [ADDR_W-1:0]  rem;
	logic               div_done;
	logic [ADDR_W-1:0]  hit_start;
	logic               erase;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= RST_FLASH_BASE;
			total_q  <= RST_FLASH_TOTAL;
			used_q   <= RST_GROUPS_USED;
			grp_q[0] <= RST_GROUP_ZERO;
			grp_q[1] <= RST_GROUP_ONE;
			grp_q[2] <= RST_GROUP_TWO;
			grp_q[3] <= RST_GROUP_THREE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLASH_BASE:  base_q   <= cfg_data[ADDR_W-1:0];
				CFG_FLASH_TOTAL: total_q  <= cfg_data[ADDR_W-1:0];
				CFG_GROUPS_USED: used_q   <= cfg_data[USED_W-1:0];
				CFG_GROUP_ZERO:  grp_q[0] <= cfg_data;
				CFG_GROUP_ONE:   grp_q[1] <= cfg_data;
				CFG_GROUP_TWO:   grp_q[2] <= cfg_data;
				CFG_GROUP_THREE: grp_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the group count to what the hardware walks
	assign used_ext = CW'(used_q);
	assign n_eff    = (used_ext > CW'(MAX_GROUPS)) ? CW'(MAX_GROUPS) : used_ext;

	// Groups past the register file read as empty
	always_comb begin
		if (idx_q < CW'(NUM_GROUP_REGS)) grp_sel = grp_q[idx_q[1:0]];
		else                             grp_sel = '0;
	end

	// A group is only passed when the address lies beyond it, so the walk stays in 32 bits
	assign offset   = addr_q - cur_q;
	assign end_addr = {1'b0, base_q} + {1'b0, total_q};
	assign cur_next = cur_q + span_q[ADDR_W-1:0];

	// Capture the item, then walk the groups
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			addr_q <= in_address;
		end
		if (cmd.setup) begin
			cur_q <= base_q;
			idx_q <= '0;
		end else if (cmd.advance) begin
			cur_q <= cur_next;
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.mul) begin
			span_q <= {{(GROUP_W-COUNT_W){1'b0}}, grp_sel[GROUP_W-1:ADDR_W]}
				* {{(GROUP_W-ADDR_W){1'b0}}, grp_sel[ADDR_W-1:0]};
			gsz_q  <= grp_sel[ADDR_W-1:0];
		end
	end

	// Offset within the group modulo the sector size
	fslt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (offset),
		.divisor   (gsz_q),
		.done      (div_done),
		.remainder (rem)
	);

	assign hit_start = addr_q - rem;
	assign erase     = !tv_q || (ts_q != hit_start) || (tsz_q != gsz_q);

	// Update tracking on finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_q  <= 1'b0;
			ts_q  <= '0;
			tsz_q <= '0;
		end else if (cmd.fin) begin
			case (cmd.kind)
				FIN_INIT: begin
					tv_q  <= 1'b0;
					ts_q  <= '0;
					tsz_q <= '0;
				end
				FIN_HIT: begin
					tv_q  <= 1'b1;
					ts_q  <= hit_start;
					tsz_q <= gsz_q;
				end
				default: ;
			endcase
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (cmd.kind == FIN_HIT) begin
				out_found_q <= 1'b1;
				out_erase_q <= erase;
				out_base_q  <= hit_start;
				out_bytes_q <= gsz_q;
			end else begin
				out_found_q <= 1'b0;
				out_erase_q <= 1'b0;
				out_base_q  <= '0;
				out_bytes_q <= '0;
			end
		end
	end

	assign sts.mode_init = mode_q;
	assign sts.in_range  = (addr_q >= base_q) && ({1'b0, addr_q} < end_addr);
	assign sts.grp_left  = idx_q < n_eff;
	assign sts.grp_hit   = (span_q != '0)
		&& ({{(GROUP_W-ADDR_W){1'b0}}, offset} < span_q);
	assign sts.div_done  = div_done;
	assign sts.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_erase = out_erase_q;
	assign out_base  = out_base_q;
	assign out_bytes = out_bytes_q;

endmodule

// ===== rtl/core/flash_sector_locator_tracker_core.sv =====
// Flash sector locator and tracker, top level.
// An init or out-of-range item goes from the range check straight to finish; otherwise the
// range check is followed by a multiply and a compare per group walked, then finish for a
// miss, or the 32-step remainder unit and then finish for a hit. Throughput: one item at a
// time, taken the cycle after the previous result is registered. A waiting result stalls the input.
// Reset (arst_n low) restores the layout registers and clears sector tracking.
module flash_sector_locator_tracker_core #(
	parameter int unsigned MAX_GROUPS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] address
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] sector_base, [63:32] sector_bytes
	output logic [1:0]  m_tuser    // [0] found, [1] erase_needed
);
	import fslt_pkg::*;

	fslt_cmd_t         cmd;
	fslt_sts_t         sts;
	logic              out_found;
	logic              out_erase;
	logic [ADDR_W-1:0] out_base;
	logic [ADDR_W-1:0] out_bytes;

	fslt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fslt_dp #(
		.MAX_GROUPS (MAX_GROUPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_mode    (s_tuser[0]),
		.in_address (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_found  (out_found),
		.out_erase  (out_erase),
		.out_base   (out_base),
		.out_bytes  (out_bytes)
	);

	assign m_tdata = {out_bytes, out_base};
	assign m_tuser = {out_erase, out_found};

endmodule

// ===== tb/sv/sector_result_checker.sv =====
// Checker for the flash sector locator and tracker: predicts each result from the
// accepted items and register writes, then compares it with the output stream.
// Depends on fslt_pkg for register indexes and reset values.
module sector_result_checker #(
	parameter int unsigned MAX_GROUPS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] address
	input  logic [0:0]  s_tuser,   // [0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // [31:0] sector_base, [63:32] sector_bytes
	input  logic [1:0]  m_tuser,   // [0] found, [1] erase_needed
	output int          fail_count,
	output int          pending,
	output int          hit_count,
	output int          erase_count
);
	import fslt_pkg::*;

	typedef struct packed {
		logic        found;
		logic [31:0] sector_base;
		logic [31:0] sector_bytes;
		logic        erase_needed;
	} sector_result_t;

	// Mirror of the layout registers
	logic [ADDR_W-1:0]  lay_base;
	logic [ADDR_W-1:0]  lay_total;
	logic [USED_W-1:0]  lay_used;
	logic [GROUP_W-1:0] lay_grp [NUM_GROUP_REGS];

	// Tracked sector
	logic               trk_valid;
	logic [ADDR_W-1:0]  trk_start;
	logic [ADDR_W-1:0]  trk_size;

	sector_result_t     sector_q [$];
	sector_result_t     want;
	sector_result_t     got;
	int                 fails;
	int                 hits;
	int                 erases;

	// Walk the groups in order; all sums are kept wide so nothing wraps
	function automatic sector_result_t locate_sector(logic [31:0] addr);
		sector_result_t   r;
		longint unsigned  a64;
		longint unsigned  cur;
		longint unsigned  cnt;
		longint unsigned  sz;
		longint unsigned  span;
		longint unsigned  idx;
		logic [39:0]      g;
		int unsigned      n;
		int unsigned      i;
		bit               hit;
		r   = '0;
		hit = 1'b0;
		a64 = addr;
		if (a64 < lay_base || a64 >= longint'(lay_base) + longint'(lay_total))
			return r;
		n   = (lay_used > MAX_GROUPS) ? MAX_GROUPS : lay_used;
		cur = lay_base;
		for (i = 0; i < n && !hit; i++) begin
			g    = (i < NUM_GROUP_REGS) ? lay_grp[i] : '0;
			cnt  = g[39:32];
			sz   = g[31:0];
			span = cnt * sz;
			if (span != 0 && a64 < cur + span) begin
				idx            = (a64 - cur) / sz;
				r.sector_base  = 32'(cur + idx * sz);
				r.sector_bytes = 32'(sz);
				r.found        = 1'b1;
				hit            = 1'b1;
			end else begin
				cur += span;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lay_base   = RST_FLASH_BASE;
			lay_total  = RST_FLASH_TOTAL;
			lay_used   = RST_GROUPS_USED;
			lay_grp[0] = RST_GROUP_ZERO;
			lay_grp[1] = RST_GROUP_ONE;
			lay_grp[2] = RST_GROUP_TWO;
			lay_grp[3] = RST_GROUP_THREE;
			trk_valid  = 1'b0;
			trk_start  = '0;
			trk_size   = '0;
			sector_q.delete();
			fails      = 0;
			hits       = 0;
			erases     = 0;
		end else begin
			// Capture register writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					CFG_FLASH_BASE:  lay_base   = cfg_data[31:0];
					CFG_FLASH_TOTAL: lay_total  = cfg_data[31:0];
					CFG_GROUPS_USED: lay_used   = cfg_data[2:0];
					CFG_GROUP_ZERO:  lay_grp[0] = cfg_data;
					CFG_GROUP_ONE:   lay_grp[1] = cfg_data;
					CFG_GROUP_TWO:   lay_grp[2] = cfg_data;
					CFG_GROUP_THREE: lay_grp[3] = cfg_data;
					default: ;
				endcase
			end

			// Compare an accepted result with the oldest prediction
			if (m_tvalid && m_tready) begin
				got.found        = m_tuser[0];
				got.erase_needed = m_tuser[1];
				got.sector_base  = m_tdata[31:0];
				got.sector_bytes = m_tdata[63:32];
				if (sector_q.size() == 0) begin
					$error("result with no item waiting: found %0d base %h bytes %h",
						got.found, got.sector_base, got.sector_bytes);
					fails++;
				end else begin
					want = sector_q.pop_front();
					if (got.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, got.found);
						fails++;
					end
					if (got.sector_base !== want.sector_base) begin
						$error("sector_base: expected %h, actual %h",
							want.sector_base, got.sector_base);
						fails++;
					end
					if (got.sector_bytes !== want.sector_bytes) begin
						$error("sector_bytes: expected %h, actual %h",
							want.sector_bytes, got.sector_bytes);
						fails++;
					end
					if (got.erase_needed !== want.erase_needed) begin
						$error("erase_needed: expected %0d, actual %0d",
							want.erase_needed, got.erase_needed);
						fails++;
					end
					if (want.found)
						hits++;
					if (want.erase_needed)
						erases++;
				end
			end

			// Predict the result of an accepted item and update tracking
			if (s_tvalid && s_tready) begin
				want = '0;
				if (s_tuser[0]) begin
					trk_valid = 1'b0;
					trk_start = '0;
					trk_size  = '0;
				end else begin
					want = locate_sector(s_tdata);
					if (want.found && (!trk_valid || trk_start != want.sector_base ||
						trk_size != want.sector_bytes)) begin
						want.erase_needed = 1'b1;
						trk_valid         = 1'b1;
						trk_start         = want.sector_base;
						trk_size          = want.sector_bytes;
					end
				end
				sector_q.push_back(want);
			end
		end
		fail_count  <= fails;
		pending     <= sector_q.size();
		hit_count   <= hits;
		erase_count <= erases;
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the flash sector locator and tracker test: clock, reset, register writes,
// address stimulus under several idling patterns, and the verdict.
// Depends on fslt_pkg, flash_sector_locator_tracker_core and sector_result_checker.
module testbench;
	import fslt_pkg::*;

	localparam int unsigned MAX_GROUPS  = 4;
	localparam int          CYCLE_LIMIT = 600000;
	localparam int          PHASES      = 9;
	localparam int          PHASE_ITEMS = 150;
	localparam int          HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [39:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	int          fail_count;
	int          pending;
	int          hit_count;
	int          erase_count;

	// Idling control
	int          send_idle  = 0;
	int          recv_stall = 0;
	bit          hold_go    = 1'b0;
	bit          hold       = 1'b0;
	int          cycle_count = 0;

	// Layout as last written, used to aim addresses
	longint unsigned lay_base  = RST_FLASH_BASE;
	longint unsigned lay_total = RST_FLASH_TOTAL;
	int unsigned     lay_used  = RST_GROUPS_USED;
	logic [39:0]     lay_grp [4] = '{RST_GROUP_ZERO, RST_GROUP_ONE, RST_GROUP_TWO,
		RST_GROUP_THREE};
	logic [31:0]     last_addr = RST_FLASH_BASE;
	int              items_sent = 0;
	int              inits_sent = 0;
	int              layouts    = 1;

	flash_sector_locator_tracker_core #(
		.MAX_GROUPS(MAX_GROUPS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sector_result_checker #(
		.MAX_GROUPS(MAX_GROUPS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.hit_count  (hit_count),
		.erase_count(erase_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("flash_sector_locator_tracker_core test failed");
			$finish;
		end
	end

	// Stall the output side at random, or fully during a hold-off
	always @(posedge clk) begin
		m_tready <= !hold && ($urandom_range(99) >= recv_stall);
	end

	// Hold the output side off for a long stretch so the block backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	task automatic cfg_write(logic [2:0] idx, logic [39:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic apply_layout(logic [31:0] base, logic [31:0] total, logic [2:0] used,
		logic [39:0] g0, logic [39:0] g1, logic [39:0] g2, logic [39:0] g3);
		cfg_write(CFG_FLASH_BASE, {8'h00, base});
		cfg_write(CFG_FLASH_TOTAL, {8'h00, total});
		cfg_write(CFG_GROUPS_USED, {37'h0, used});
		cfg_write(CFG_GROUP_ZERO, g0);
		cfg_write(CFG_GROUP_ONE, g1);
		cfg_write(CFG_GROUP_TWO, g2);
		cfg_write(CFG_GROUP_THREE, g3);
		cfg_we     <= 1'b0;
		@(posedge clk);
		lay_base   = base;
		lay_total  = total;
		lay_used   = used;
		lay_grp[0] = g0;
		lay_grp[1] = g1;
		lay_grp[2] = g2;
		lay_grp[3] = g3;
		layouts++;
	endtask

	// Pick a layout: mostly small sectors, now and then empty or huge groups
	task automatic random_layout();
		logic [31:0]     base;
		logic [31:0]     total;
		logic [2:0]      used;
		logic [39:0]     g [4];
		logic [7:0]      cnt;
		logic [31:0]     sz;
		longint unsigned sum;
		int              i;
		int              r;
		sum = 0;
		r = $urandom_range(99);
		if (r < 10)
			base = '0;
		else if (r < 15)
			base = 32'hFFFF_FFFF - $urandom_range(16'hFFFF);
		else if (r < 60)
			base = $urandom & 32'hFFF0_0000;
		else
			base = $urandom;
		for (i = 0; i < 4; i++) begin
			r = $urandom_range(99);
			if (r < 10)
				cnt = '0;
			else if (r < 15)
				cnt = 8'hFF;
			else if (r < 25)
				cnt = 8'($urandom);
			else
				cnt = 8'($urandom_range(1, 16));
			r = $urandom_range(99);
			if (r < 8)
				sz = '0;
			else if (r < 12)
				sz = 32'hFFFF_FFFF;
			else if (r < 18)
				sz = $urandom;
			else if (r < 35)
				sz = $urandom_range(1, 5000);
			else
				sz = 32'h1 << $urandom_range(4, 18);
			g[i] = {cnt, sz};
			sum += longint'(cnt) * longint'(sz);
		end
		used = ($urandom_range(99) < 75) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
		r = $urandom_range(99);
		if (sum > 32'hFFFF_FFFF)
			sum = 32'hFFFF_FFFF;
		if (r < 60)
			total = 32'(sum);
		else if (r < 80)
			total = $urandom;
		else
			total = (sum > 4096) ? 32'(sum - $urandom_range(4096)) : 32'(sum);
		apply_layout(base, total, used, g[0], g[1], g[2], g[3]);
	endtask

	// Aim an address at the layout: sector edges, the range edges, the last sector, noise
	function automatic logic [31:0] pick_address();
		longint unsigned cur;
		longint unsigned cnt;
		longint unsigned sz;
		longint unsigned room;
		longint unsigned lim;
		longint unsigned start;
		int unsigned     n;
		int unsigned     g;
		int unsigned     i;
		int              r;
		logic [31:0]     a;
		n    = (lay_used > MAX_GROUPS) ? MAX_GROUPS : lay_used;
		room = 0;
		for (i = 0; i < n; i++)
			room += longint'(lay_grp[i][39:32]) * longint'(lay_grp[i][31:0]);
		lim = (lay_total < room) ? lay_total : room;
		r = $urandom_range(99);
		if (r < 8) begin
			a = $urandom;
		end else if (r < 16) begin
			case ($urandom_range(2))
				0:       a = 32'(lay_base - 1);
				1:       a = 32'(lay_base + lay_total);
				default: a = 32'(lay_base + lay_total - 1);
			endcase
		end else if (r < 26) begin
			a = last_addr;
		end else if (r < 40) begin
			a = last_addr + $urandom_range(255);
		end else if (r < 62 && n > 0) begin
			g   = $urandom_range(n - 1);
			cur = lay_base;
			for (i = 0; i < g; i++)
				cur += longint'(lay_grp[i][39:32]) * longint'(lay_grp[i][31:0]);
			cnt = lay_grp[g][39:32];
			sz  = lay_grp[g][31:0];
			if (cnt * sz == 0) begin
				a = 32'(lay_base + $urandom_range(255));
			end else begin
				start = cur + ({$urandom, $urandom} % cnt) * sz;
				case ($urandom_range(2))
					0:       a = 32'(start);
					1:       a = 32'(start - 1);
					default: a = 32'(start + sz - 1);
				endcase
			end
		end else if (lim != 0) begin
			a = 32'(lay_base + ({$urandom, $urandom} % lim));
		end else begin
			a = 32'(lay_base + $urandom_range(255));
		end
		return a;
	endfunction

	// Offer one item, keeping tvalid high into the next item when there is no gap
	task automatic send_item(logic m, logic [31:0] a);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= a;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (m)
			inits_sent++;
		else
			last_addr = a;
	endtask

	// Wait for every predicted result, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	initial begin
		int  p;
		int  k;
		logic m;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset layout: init first, sector edges, range edges, repeat hits
		send_item(1'b1, 32'hFFFF_FFFF);
		send_item(1'b0, RST_FLASH_BASE);
		send_item(1'b0, RST_FLASH_BASE + 32'h3FFF);
		send_item(1'b0, RST_FLASH_BASE + 32'h4000);
		send_item(1'b0, RST_FLASH_BASE - 1);
		send_item(1'b0, 32'h0);
		send_item(1'b0, RST_FLASH_BASE + RST_FLASH_TOTAL - 1);
		send_item(1'b0, RST_FLASH_BASE + RST_FLASH_TOTAL);
		send_item(1'b1, 32'h0);
		send_item(1'b0, RST_FLASH_BASE + RST_FLASH_TOTAL - 1);
		send_item(1'b0, RST_FLASH_BASE + 32'h10000);
		drain();

		// A write to an unused index must leave the layout alone
		cfg_write(CFG_NONE, 40'hFF_FFFF_FFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_item(1'b0, RST_FLASH_BASE + 32'h8000);
		drain();

		// Top of the address space, empty groups, groups used above the limit
		apply_layout(32'hFFFF_F000, 32'hFFFF_FFFF, 3'd7, {8'h00, 32'h100}, {8'h05, 32'h0},
			{8'hFF, 32'h10}, {8'hFF, 32'hFFFF_FFFF});
		send_item(1'b0, 32'hFFFF_F000);
		send_item(1'b0, 32'hFFFF_F7FF);
		send_item(1'b0, 32'hFFFF_FFEF);
		send_item(1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 32'hFFFF_EFFF);
		drain();

		// No groups in use: every address misses
		apply_layout(32'h0, 32'hFFFF_FFFF, 3'd0, {8'h01, 32'h1000}, {8'h01, 32'h1000},
			{8'h01, 32'h1000}, {8'h01, 32'h1000});
		send_item(1'b0, 32'h0);
		send_item(1'b0, 32'h1234_5678);
		drain();

		// Empty range, then an address in range past all groups
		apply_layout(32'h0, 32'h0, 3'd4, {8'h01, 32'h100}, {8'h01, 32'h100},
			{8'h01, 32'h100}, {8'h01, 32'h100});
		send_item(1'b0, 32'h0);
		drain();
		apply_layout(32'h0, 32'hFFFF_FFFF, 3'd4, {8'h01, 32'h100}, {8'h01, 32'h100},
			{8'h01, 32'h100}, {8'h01, 32'h100});
		send_item(1'b0, 32'h3FF);
		send_item(1'b0, 32'h400);
		drain();

		// Random phases, each with its own layout and one of four idling patterns
		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 73; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 73; end
				default: begin send_idle = 12; recv_stall = 12; end
			endcase
			if (p == 0)
				apply_layout(RST_FLASH_BASE, RST_FLASH_TOTAL, RST_GROUPS_USED,
					RST_GROUP_ZERO, RST_GROUP_ONE, RST_GROUP_TWO, RST_GROUP_THREE);
			else if (p == 4)
				apply_layout($urandom & 32'hFF00_0000, 32'hFFFF_FFFF, 3'd4,
					{8'hFF, 32'h100}, {8'hFF, 32'h1000}, {8'hFF, 32'h10}, {8'hFF, 32'h4000});
			else
				random_layout();
			if (p == 4)
				hold_go = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				m = ($urandom_range(99) < 6);
				send_item(m, m ? $urandom : pick_address());
			end
			drain();
		end

		$display("Ran %0d items (%0d inits) over %0d layouts under four idling patterns;",
			items_sent, inits_sent, layouts);
		$display("%0d sector hits and %0d erase flags were checked.", hit_count, erase_count);
		if (fail_count == 0 && pending == 0)
			$display("flash_sector_locator_tracker_core test passed");
		else
			$display("flash_sector_locator_tracker_core test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/fslt_pkg.sv
rtl/core/fslt_div.sv
rtl/core/fslt_ctrl.sv
rtl/core/fslt_dp.sv
rtl/core/flash_sector_locator_tracker_core.sv
tb/sv/sector_result_checker.sv
tb/sv/testbench.sv
